FILE: design/delay_task_timer_queue_macros.svh
// Assertion macros used by the timer queue top level.
`ifndef DELAY_TASK_TIMER_QUEUE_MACROS_SVH
`define DELAY_TASK_TIMER_QUEUE_MACROS_SVH
`ifndef ASSERT_OFF
`define DTQ_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define DTQ_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define DTQ_ASSERT(label, clk, rst_n, prop, msg)
`define DTQ_ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

FILE: design/dtq_pkg.sv
// Types and constants of the timer queue.
`timescale 1ns / 1ps
package dtq_pkg;
	localparam int TIME_W = 48;
	localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

	typedef enum logic [1:0] {
		OP_ADD    = 2'd0,
		OP_REMOVE = 2'd1,
		OP_TICK   = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		KIND_ADD    = 2'd0,
		KIND_REMOVE = 2'd1,
		KIND_FIRED  = 2'd2,
		KIND_IDLE   = 2'd3
	} kind_t;

	typedef enum logic {
		REG_ENABLE   = 1'b0,
		REG_MAX_WAIT = 1'b1
	} reg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SCAN,      // read entry, compare
		ST_SHIFT_UP,  // move entries up for an insert
		ST_SHIFT_DN,  // move entries down for a delete
		ST_HEAD,      // read head for tick
		ST_HEAD_CHK,
		ST_OUT        // result waits to be taken
	} state_t;
endpackage

FILE: design/delay_task_timer_queue.sv
// Top level of the sorted timer queue.
`timescale 1ns / 1ps
// Sorted timer queue. Tasks live in one synchronous memory in ascending due time order
// (entry 0 is the earliest). One item is handled at a time by a sequencer around the
// memory's single read port: an add scans for its place entry by entry and then moves
// every later entry up one slot, a remove scans for the token and moves later entries
// down in the same way, and a tick reads the head and, while it is due (up to MAX_FIRE
// tasks per tick), parks it as the pending fired result, drops it from the memory and
// reads the new head. A fired result is only sent once the next head has been checked,
// so that the final one can carry the last flag. A tick that fires moves the remaining
// entries down for every fired task. Each result sits in an output register until taken,
// and the sequencer waits while that register is occupied; the memory needs no clearing
// after reset, since only entries below the fill count are read.
`include "delay_task_timer_queue_macros.svh"
module delay_task_timer_queue #(
	parameter int MAX_TASKS  = 32,
	parameter int TOKEN_BITS = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [1:0]              operation,
	input  logic [31:0]             delay_us,
	input  logic [15:0]             task_id,
	input  logic [TOKEN_BITS-1:0]   token,
	input  logic [15:0]             elapsed_us,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [1:0]              kind,
	output logic [TOKEN_BITS-1:0]   token_out,
	output logic [15:0]             fired_task,
	output logic                    found,
	output logic [31:0]             wait_us,
	output logic                    last,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [0:0]              cfg_index,
	input  logic [31:0]             cfg_data
);
	import dtq_pkg::*;

	localparam int AW = $clog2(MAX_TASKS);
	localparam int CW = $clog2(MAX_TASKS + 1);
	localparam int EW = TIME_W + TOKEN_BITS + 16;
	localparam int MAX_FIRE = 32;

	// Entry layout: {due, token, task}.
	logic [EW-1:0] mem [MAX_TASKS];
	logic [EW-1:0] rd_q;
	logic          rd_en;
	logic [AW-1:0] rd_addr;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [EW-1:0] wr_data;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	logic [TIME_W-1:0]     rd_due;
	logic [TOKEN_BITS-1:0] rd_tok;
	logic [15:0]           rd_task;
	assign rd_due  = rd_q[EW-1 -: TIME_W];
	assign rd_tok  = rd_q[16 +: TOKEN_BITS];
	assign rd_task = rd_q[15:0];

	state_t state_q, state_d;
	logic                  enable_q;
	logic [31:0]           max_wait_q;
	logic [TIME_W-1:0]     now_q;
	logic [CW-1:0]         count_q;
	logic [TOKEN_BITS-1:0] next_tok_q;
	logic [CW-1:0]         idx_q;   // scan index / shift index
	logic [CW-1:0]         pos_q;   // insert or delete position
	logic [5:0]            nfire_q;
	logic [1:0]            op_q;
	logic [TIME_W-1:0]     due_q;
	logic [15:0]           task_q;
	logic [TOKEN_BITS-1:0] tok_q;
	logic                  phase_q; // shift: 0 read issued, 1 data ready
	// Tick shifting back to the head reuses the delete walk at position 0.
	logic                  tick_mode_q;
	// Fired task held back until the next head has been checked.
	logic                  pend_q;
	logic [TOKEN_BITS-1:0] pend_tok_q;
	logic [15:0]           pend_task_q;

	// Output register.
	logic                  ov_q;
	logic [1:0]            kind_q;
	logic [TOKEN_BITS-1:0] tok_out_q;
	logic [15:0]           ftask_q;
	logic                  found_q;
	logic [31:0]           wait_q;
	logic                  last_q;

	assign out_valid  = ov_q;
	assign kind       = kind_q;
	assign token_out  = tok_out_q;
	assign fired_task = ftask_q;
	assign found      = found_q;
	assign wait_us    = wait_q;
	assign last       = last_q;
	assign cfg_ready  = 1'b1;

	logic in_acc, out_free;
	assign out_free = !ov_q || !out_stall;
	assign in_stall = (state_q != ST_IDLE) || !out_free;
	assign in_acc   = in_valid && !in_stall;

	// Saturating time sums.
	logic [TIME_W:0] due_sum, now_sum;
	assign due_sum = {1'b0, now_q} + {{(TIME_W-31){1'b0}}, delay_us};
	assign now_sum = {1'b0, now_q} + {{(TIME_W-15){1'b0}}, elapsed_us};

	logic [TOKEN_BITS-1:0] tok_inc;
	assign tok_inc = (next_tok_q + 1'b1 == '0) ? {{(TOKEN_BITS-1){1'b0}}, 1'b1}
		: next_tok_q + 1'b1;

	// Wait until the head is due, clamped.
	logic [TIME_W-1:0] gap;
	logic [31:0]       head_wait;
	assign gap = (rd_due > now_q) ? rd_due - now_q : '0;
	assign head_wait = (gap < {{(TIME_W-32){1'b0}}, max_wait_q}) ? gap[31:0] : max_wait_q;

	// Result to load into the output register.
	logic                  emit;
	logic                  hold;
	logic [1:0]            e_kind;
	logic [TOKEN_BITS-1:0] e_tok;
	logic [15:0]           e_task;
	logic                  e_found;
	logic [31:0]           e_wait;
	logic                  e_last;

	always_comb begin
		state_d = state_q;
		rd_en = 1'b0;
		rd_addr = '0;
		wr_en = 1'b0;
		wr_addr = '0;
		wr_data = rd_q;
		emit = 1'b0;
		hold = 1'b0;
		e_kind = KIND_IDLE;
		e_tok = '0;
		e_task = '0;
		e_found = 1'b0;
		e_wait = '0;
		e_last = 1'b1;
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					rd_en = 1'b1;
					rd_addr = '0;
					case (op_t'(operation))
						OP_ADD: begin
							if (!enable_q || task_id == '0 || count_q >= CW'(MAX_TASKS)) begin
								emit = 1'b1;
								e_kind = KIND_ADD;
							end else if (count_q == '0) begin
								state_d = ST_SHIFT_UP;
							end else begin
								state_d = ST_SCAN;
							end
						end
						OP_REMOVE: begin
							if (!enable_q || count_q == '0) begin
								emit = 1'b1;
								e_kind = KIND_REMOVE;
							end else begin
								state_d = ST_SCAN;
							end
						end
						default: begin
							if (!enable_q) begin
								emit = 1'b1;
								e_wait = max_wait_q;
							end else if (count_q == '0) begin
								emit = 1'b1;
								e_wait = max_wait_q;
							end else begin
								state_d = ST_HEAD_CHK;
							end
						end
					endcase
				end
			end
			ST_SCAN: begin
				// rd_q holds entry idx_q
				if (op_q == OP_ADD) begin
					if (rd_due > due_q) begin
						state_d = ST_SHIFT_UP;
						rd_en = 1'b1;
						rd_addr = AW'(count_q - 1'b1);
					end else if (idx_q + 1'b1 == count_q) begin
						state_d = ST_SHIFT_UP;
						rd_en = 1'b1;
						rd_addr = AW'(count_q - 1'b1);
					end else begin
						rd_en = 1'b1;
						rd_addr = AW'(idx_q + 1'b1);
					end
				end else begin
					if (rd_tok == tok_q) begin
						state_d = ST_SHIFT_DN;
						rd_en = 1'b1;
						rd_addr = AW'(idx_q + 1'b1);
					end else if (idx_q + 1'b1 == count_q) begin
						emit = 1'b1;
						e_kind = KIND_REMOVE;
						state_d = ST_OUT;
					end else begin
						rd_en = 1'b1;
						rd_addr = AW'(idx_q + 1'b1);
					end
				end
			end
			ST_SHIFT_UP: begin
				// idx_q walks from count down to pos; rd_q holds entry idx_q-1 when phase 1
				if (idx_q == pos_q) begin
					wr_en = 1'b1;
					wr_addr = AW'(pos_q);
					wr_data = {due_q, next_tok_q, task_q};
					emit = 1'b1;
					e_kind = KIND_ADD;
					e_tok = next_tok_q;
					state_d = ST_OUT;
				end else if (phase_q) begin
					wr_en = 1'b1;
					wr_addr = AW'(idx_q);
					if (idx_q - 1'b1 != pos_q) begin
						rd_en = 1'b1;
						rd_addr = AW'(idx_q - 2'd2);
					end
				end
			end
			ST_SHIFT_DN: begin
				// idx_q walks from pos up; rd_q holds entry idx_q+1
				if (idx_q + 1'b1 >= count_q) begin
					if (tick_mode_q) begin
						state_d = ST_HEAD;
					end else begin
						emit = 1'b1;
						e_kind = KIND_REMOVE;
						e_found = 1'b1;
						state_d = ST_OUT;
					end
				end else if (phase_q) begin
					wr_en = 1'b1;
					wr_addr = AW'(idx_q);
					rd_en = 1'b1;
					rd_addr = AW'(idx_q + 2'd2);
				end
			end
			ST_HEAD: begin
				rd_en = 1'b1;
				rd_addr = '0;
				state_d = ST_HEAD_CHK;
			end
			ST_HEAD_CHK: begin
				if (op_q == OP_TICK && count_q != '0 && rd_due <= now_q
						&& nfire_q != 6'(MAX_FIRE)) begin
					// The head is due: the task parked before it is not the last one.
					if (pend_q) begin
						emit = 1'b1;
						e_kind = KIND_FIRED;
						e_tok = pend_tok_q;
						e_task = pend_task_q;
						e_last = 1'b0;
					end
					rd_en = 1'b1;
					rd_addr = AW'(1);
					state_d = ST_SHIFT_DN;
				end else if (pend_q) begin
					emit = 1'b1;
					e_kind = KIND_FIRED;
					e_tok = pend_tok_q;
					e_task = pend_task_q;
					state_d = ST_OUT;
				end else begin
					emit = 1'b1;
					e_wait = (count_q == '0) ? max_wait_q : head_wait;
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
		// A result that finds the output register occupied freezes the sequencer.
		if (emit && !out_free && state_q != ST_IDLE) begin
			emit = 1'b0;
			hold = 1'b1;
			wr_en = 1'b0;
			rd_en = 1'b0;
			state_d = state_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			enable_q    <= 1'b0;
			max_wait_q  <= 32'd10000;
			now_q       <= '0;
			count_q     <= '0;
			next_tok_q  <= '0;
			ov_q        <= 1'b0;
			idx_q       <= '0;
			pos_q       <= '0;
			nfire_q     <= '0;
			phase_q     <= 1'b0;
			tick_mode_q <= 1'b0;
			pend_q      <= 1'b0;
			op_q        <= OP_ADD;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				case (reg_t'(cfg_index))
					REG_ENABLE:   enable_q <= cfg_data[0];
					REG_MAX_WAIT: max_wait_q <= cfg_data;
					default: ;
				endcase
			end
			if (emit) begin
				ov_q <= 1'b1;
			end else if (!out_stall) begin
				ov_q <= 1'b0;
			end
			if (!hold) begin
				case (state_q)
					ST_IDLE: begin
						if (in_acc) begin
							op_q <= operation;
							idx_q <= '0;
							nfire_q <= '0;
							phase_q <= 1'b0;
							tick_mode_q <= 1'b0;
							pend_q <= 1'b0;
							if (operation == OP_TICK) begin
								now_q <= now_sum[TIME_W] ? TIME_MAX : now_sum[TIME_W-1:0];
							end
							if (operation == OP_ADD && state_d != ST_IDLE) begin
								next_tok_q <= tok_inc;
								pos_q <= '0;
							end
						end
					end
					ST_SCAN: begin
						if (op_q == OP_ADD) begin
							if (state_d == ST_SHIFT_UP) begin
								pos_q <= (rd_due > due_q) ? idx_q : idx_q + 1'b1;
								idx_q <= count_q;
								phase_q <= 1'b1;
							end else begin
								idx_q <= idx_q + 1'b1;
							end
						end else if (state_d == ST_SHIFT_DN) begin
							pos_q <= idx_q;
							phase_q <= 1'b1;
						end else if (state_d == ST_SCAN) begin
							idx_q <= idx_q + 1'b1;
						end
					end
					ST_SHIFT_UP: begin
						if (state_d == ST_OUT) begin
							count_q <= count_q + 1'b1;
						end else if (phase_q) begin
							idx_q <= idx_q - 1'b1;
							phase_q <= (idx_q - 1'b1 != pos_q);
						end else begin
							phase_q <= 1'b1;
						end
					end
					ST_SHIFT_DN: begin
						if (idx_q + 1'b1 >= count_q) begin
							count_q <= count_q - 1'b1;
						end else if (phase_q) begin
							idx_q <= idx_q + 1'b1;
						end
					end
					ST_HEAD_CHK: begin
						if (state_d == ST_SHIFT_DN) begin
							pend_q <= 1'b1;
							nfire_q <= nfire_q + 1'b1;
							tick_mode_q <= 1'b1;
							idx_q <= '0;
							phase_q <= 1'b1;
						end else begin
							pend_q <= 1'b0;
						end
					end
					default: ;
				endcase
			end
		end
	end

	// Input fields held for the walk, the parked fired task and the result register.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_acc) begin
			task_q <= task_id;
			tok_q  <= token;
			due_q  <= due_sum[TIME_W] ? TIME_MAX : due_sum[TIME_W-1:0];
		end
		if (state_q == ST_HEAD_CHK && state_d == ST_SHIFT_DN) begin
			pend_tok_q  <= rd_tok;
			pend_task_q <= rd_task;
		end
		if (emit) begin
			kind_q    <= e_kind;
			tok_out_q <= e_tok;
			ftask_q   <= e_task;
			found_q   <= e_found;
			wait_q    <= e_wait;
			last_q    <= e_last;
		end
	end

	`DTQ_ASSERT(a_count_max, clk, arst_n, count_q <= CW'(MAX_TASKS), "fill count overflow")
	`DTQ_ASSERT_NEVER(a_stall_busy, clk, arst_n, in_acc && state_q != ST_IDLE, "item taken while busy")
	`DTQ_ASSERT(a_emit_room, clk, arst_n, emit |-> out_free, "result overwritten")
endmodule
